FILE: src/fsd_pkg.sv
// Shared types, codes and defaults for the palette dither block.
package fsd_pkg;

    localparam int MAX_WIDTH_DEF       = 1024;
    localparam int PALETTE_ENTRIES_DEF = 16;

    localparam logic [1:0] FUNC_PIXEL = 2'd0;
    localparam logic [1:0] FUNC_DRAIN = 2'd1;
    localparam logic [1:0] FUNC_PAL   = 2'd2;
    localparam logic [1:0] FUNC_RSVD  = 2'd3;

    localparam logic CFG_WIDTH = 1'b0;
    localparam logic CFG_PSIZE = 1'b1;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] palette_slot;
    } item_t;

    typedef struct packed {
        logic [3:0] color_index;
        logic       end_of_row;
        logic       last_of_run;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_PIX,
        ST_LD_PIX,
        ST_SQ,
        ST_CMP,
        ST_PWAIT,
        ST_EWAIT,
        ST_ERR,
        ST_TRD,
        ST_TWR,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        TGT_RIGHT,
        TGT_LL,
        TGT_DOWN,
        TGT_LR
    } tgt_t;

endpackage

FILE: src/fsd_diffuse.sv
// Weighted error add with clamp for one RGB word.
module fsd_diffuse (
    input  logic [23:0]       pixel,
    input  logic signed [8:0] err_r,
    input  logic signed [8:0] err_g,
    input  logic signed [8:0] err_b,
    input  fsd_pkg::tgt_t     tgt,
    output logic [23:0]       pixel_out
);
    import fsd_pkg::*;

    logic signed [8:0]  err [3];
    logic signed [12:0] prod [3];
    logic signed [12:0] sum [3];
    logic [7:0]         chan [3];

    assign err[0] = err_r;
    assign err[1] = err_g;
    assign err[2] = err_b;
    assign chan[0] = pixel[23:16];
    assign chan[1] = pixel[15:8];
    assign chan[2] = pixel[7:0];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            case (tgt)
                TGT_RIGHT: prod[c] = 13'(err[c]) * 13'sd7;
                TGT_LL:    prod[c] = 13'(err[c]) * 13'sd3;
                TGT_DOWN:  prod[c] = 13'(err[c]) * 13'sd5;
                TGT_LR:    prod[c] = 13'(err[c]);
                default:   prod[c] = '0;
            endcase
            sum[c] = $signed({5'b0, chan[c]}) + (prod[c] >>> 4);
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (sum[c] < 0)
            begin
                pixel_out[23-8*c -: 8] = 8'd0;
            end
            else if (sum[c] > 13'sd255)
            begin
                pixel_out[23-8*c -: 8] = 8'd255;
            end
            else
            begin
                pixel_out[23-8*c -: 8] = sum[c][7:0];
            end
        end
    end

endmodule

FILE: src/floyd_steinberg_palette_dither.sv
// Floyd-Steinberg palette dither top level: sequencer, row and palette memories.
// A finished pixel runs the palette search and then the error writes; a row-end pixel
// item finishes two pixels back to back.
// Items are taken one at a time; palette writes and pixels with no result are taken in idle.
// The search loop over the palette squares one channel per cycle.
// Reset: control state cleared at once; row and palette memories hold no reset.
module floyd_steinberg_palette_dither #(
    parameter int MAX_WIDTH       = fsd_pkg::MAX_WIDTH_DEF,
    parameter int PALETTE_ENTRIES = fsd_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  fsd_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output fsd_pkg::result_t result,
    input  logic            cfg_write,
    input  logic            cfg_index,
    input  logic [10:0]     cfg_data
);
    import fsd_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int AW = XW + 1;
    localparam int WW = (XW + 1 > 11) ? XW + 1 : 11;
    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int NW = (PW + 1 > 5) ? PW + 1 : 5;

    logic [23:0] row_mem [2*MAX_WIDTH];
    logic [23:0] pal_mem [PALETTE_ENTRIES];
    logic [23:0] row_rdata_reg;
    logic [23:0] pal_rdata_reg;
    logic [AW-1:0] row_raddr, row_waddr;
    logic [23:0]   row_wdata;
    logic          row_we;
    logic [PW-1:0] pal_raddr;

    state_t state_reg, state_next;
    logic [10:0] width_reg;
    logic [4:0]  psize_reg;
    logic [XW-1:0] col_reg, col_next;
    logic [XW-1:0] dcol_reg, dcol_next;
    logic row_pend_reg, row_pend_next;
    logic sel_reg, sel_next;
    logic cb_reg, cb_next;
    logic [XW-1:0] fx_reg, fx_next;
    logic down_reg, down_next;
    logic right_reg, right_next;
    logic second_reg, second_next;
    logic eor_reg, eor_next;
    logic last_reg, last_next;
    logic [23:0] pix_reg, pix_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [1:0] ch_reg, ch_next;
    logic [17:0] acc_reg, acc_next;
    logic [17:0] bestd_reg, bestd_next;
    logic [PW-1:0] best_reg, best_next;
    logic signed [8:0] err_reg [3];
    logic signed [8:0] err_next [3];
    tgt_t tgt_reg, tgt_next;
    logic out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic accept, out_take;
    logic [WW-1:0] w_eff;
    logic [NW-1:0] n_eff;
    logic [WW-1:0] col_p1, dcol_p1;
    logic col_end, dcol_end;
    logic tgt_en;
    logic [AW-1:0] tgt_addr;
    logic [7:0] pch, qch;
    logic signed [8:0] diff;
    logic [15:0] sq;
    logic [23:0] diffused;
    logic pal_we;

    assign accept   = item_valid && !item_stall;
    assign out_take = out_valid_reg && !result_stall;
    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        if (width_reg < 11'd2)
        begin
            w_eff = WW'(2);
        end
        else if (WW'(width_reg) > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_reg);
        end
        if (psize_reg == 5'd0)
        begin
            n_eff = NW'(1);
        end
        else if (NW'(psize_reg) > NW'(PALETTE_ENTRIES))
        begin
            n_eff = NW'(PALETTE_ENTRIES);
        end
        else
        begin
            n_eff = NW'(psize_reg);
        end
    end

    assign col_p1   = WW'(col_reg) + WW'(1);
    assign dcol_p1  = WW'(dcol_reg) + WW'(1);
    assign col_end  = (col_p1 >= w_eff);
    assign dcol_end = (dcol_p1 >= w_eff);

    always_comb
    begin
        case (tgt_reg)
            TGT_RIGHT:
            begin
                tgt_en   = right_reg;
                tgt_addr = {cb_reg, fx_reg + XW'(1)};
            end
            TGT_LL:
            begin
                tgt_en   = down_reg && (fx_reg != '0);
                tgt_addr = {~cb_reg, fx_reg - XW'(1)};
            end
            TGT_DOWN:
            begin
                tgt_en   = down_reg;
                tgt_addr = {~cb_reg, fx_reg};
            end
            TGT_LR:
            begin
                tgt_en   = down_reg && right_reg;
                tgt_addr = {~cb_reg, fx_reg + XW'(1)};
            end
            default:
            begin
                tgt_en   = 1'b0;
                tgt_addr = '0;
            end
        endcase
    end

    // squared distance, one channel per cycle
    always_comb
    begin
        case (ch_reg)
            2'd0:
            begin
                pch = pix_reg[23:16];
                qch = pal_rdata_reg[23:16];
            end
            2'd1:
            begin
                pch = pix_reg[15:8];
                qch = pal_rdata_reg[15:8];
            end
            default:
            begin
                pch = pix_reg[7:0];
                qch = pal_rdata_reg[7:0];
            end
        endcase
        diff = $signed({1'b0, pch}) - $signed({1'b0, qch});
        sq   = 16'(18'(diff) * 18'(diff));
    end

    fsd_diffuse u_diffuse (
        .pixel     (row_rdata_reg),
        .err_r     (err_reg[0]),
        .err_g     (err_reg[1]),
        .err_b     (err_reg[2]),
        .tgt       (tgt_reg),
        .pixel_out (diffused)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.func == FUNC_PIXEL && dcol_reg == '0
                    && row_pend_reg && col_reg != '0)
                begin
                    state_next = ST_RD_PIX;
                end
                else if (accept && item.func == FUNC_DRAIN && row_pend_reg
                         && col_reg == '0)
                begin
                    state_next = ST_RD_PIX;
                end
            end
            ST_RD_PIX: state_next = ST_LD_PIX;
            ST_LD_PIX: state_next = ST_SQ;
            ST_SQ:
            begin
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (idx_reg + NW'(1) >= n_eff)
                begin
                    state_next = ST_EWAIT;
                end
                else
                begin
                    state_next = ST_PWAIT;
                end
            end
            ST_PWAIT: state_next = ST_SQ;
            ST_EWAIT: state_next = ST_ERR;
            ST_ERR:   state_next = ST_TRD;
            ST_TRD:
            begin
                if (tgt_en)
                begin
                    state_next = ST_TWR;
                end
                else if (tgt_reg == TGT_LR)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_TWR:
            begin
                if (tgt_reg == TGT_LR)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_TRD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    state_next = second_reg ? ST_RD_PIX : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        col_next       = col_reg;
        dcol_next      = dcol_reg;
        row_pend_next  = row_pend_reg;
        sel_next       = sel_reg;
        cb_next        = cb_reg;
        fx_next        = fx_reg;
        down_next      = down_reg;
        right_next     = right_reg;
        second_next    = second_reg;
        eor_next       = eor_reg;
        last_next      = last_reg;
        pix_next       = pix_reg;
        idx_next       = idx_reg;
        ch_next        = ch_reg;
        acc_next       = acc_reg;
        bestd_next     = bestd_reg;
        best_next      = best_reg;
        err_next       = err_reg;
        tgt_next       = tgt_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_next       = out_reg;
        row_we         = 1'b0;
        row_waddr      = tgt_addr;
        row_wdata      = diffused;
        row_raddr      = tgt_addr;
        pal_we         = 1'b0;
        pal_raddr      = (state_reg == ST_EWAIT) ? best_reg : idx_reg[PW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.func)
                        FUNC_PAL:
                        begin
                            pal_we = (32'(item.palette_slot) < PALETTE_ENTRIES);
                        end
                        FUNC_PIXEL:
                        begin
                            if (dcol_reg == '0)
                            begin
                                row_we    = 1'b1;
                                row_waddr = {~sel_reg, col_reg};
                                row_wdata = {item.red, item.green, item.blue};
                                cb_next     = sel_reg;
                                fx_next     = col_reg - XW'(1);
                                down_next   = 1'b1;
                                right_next  = 1'b1;
                                second_next = col_end;
                                eor_next    = 1'b0;
                                last_next   = !col_end;
                                if (col_end)
                                begin
                                    sel_next      = ~sel_reg;
                                    row_pend_next = 1'b1;
                                    col_next      = '0;
                                end
                                else
                                begin
                                    col_next = col_reg + XW'(1);
                                end
                            end
                        end
                        FUNC_DRAIN:
                        begin
                            if (row_pend_reg && col_reg == '0)
                            begin
                                cb_next     = sel_reg;
                                fx_next     = dcol_reg;
                                down_next   = 1'b0;
                                right_next  = !dcol_end;
                                second_next = 1'b0;
                                eor_next    = dcol_end;
                                last_next   = 1'b1;
                                if (dcol_end)
                                begin
                                    row_pend_next = 1'b0;
                                    dcol_next     = '0;
                                end
                                else
                                begin
                                    dcol_next = dcol_reg + XW'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_PIX:
            begin
                row_raddr  = {cb_reg, fx_reg};
                idx_next   = '0;
                ch_next    = 2'd0;
                acc_next   = '0;
                bestd_next = '1;
                best_next  = '0;
            end
            ST_LD_PIX:
            begin
                pix_next = row_rdata_reg;
            end
            ST_SQ:
            begin
                acc_next = acc_reg + 18'(sq);
                ch_next  = ch_reg + 2'd1;
            end
            ST_CMP:
            begin
                if (acc_reg < bestd_reg)
                begin
                    bestd_next = acc_reg;
                    best_next  = idx_reg[PW-1:0];
                end
                idx_next = idx_reg + NW'(1);
                ch_next  = 2'd0;
                acc_next = '0;
            end
            ST_ERR:
            begin
                err_next[0] = $signed({1'b0, pix_reg[23:16]})
                              - $signed({1'b0, pal_rdata_reg[23:16]});
                err_next[1] = $signed({1'b0, pix_reg[15:8]})
                              - $signed({1'b0, pal_rdata_reg[15:8]});
                err_next[2] = $signed({1'b0, pix_reg[7:0]})
                              - $signed({1'b0, pal_rdata_reg[7:0]});
                tgt_next = TGT_RIGHT;
            end
            ST_TRD:
            begin
                if (!tgt_en && tgt_reg != TGT_LR)
                begin
                    tgt_next = tgt_t'(tgt_reg + 2'd1);
                end
            end
            ST_TWR:
            begin
                row_we = 1'b1;
                if (tgt_reg != TGT_LR)
                begin
                    tgt_next = tgt_t'(tgt_reg + 2'd1);
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next        = 1'b1;
                    out_next.color_index  = 4'(best_reg);
                    out_next.end_of_row   = eor_reg;
                    out_next.last_of_run  = last_reg;
                    if (second_reg)
                    begin
                        second_next = 1'b0;
                        fx_next     = fx_reg + XW'(1);
                        right_next  = 1'b0;
                        eor_next    = 1'b1;
                        last_next   = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_rdata_reg <= row_mem[row_raddr];
        if (pal_we)
        begin
            pal_mem[PW'(item.palette_slot)] <= {item.red, item.green, item.blue};
        end
        pal_rdata_reg <= pal_mem[pal_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= 11'd640;
            psize_reg     <= 5'd16;
            col_reg       <= '0;
            dcol_reg      <= '0;
            row_pend_reg  <= 1'b0;
            sel_reg       <= 1'b0;
            second_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            dcol_reg      <= dcol_next;
            row_pend_reg  <= row_pend_next;
            sel_reg       <= sel_next;
            second_reg    <= second_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_WIDTH: width_reg <= cfg_data;
                    CFG_PSIZE: psize_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cb_reg    <= cb_next;
        fx_reg    <= fx_next;
        down_reg  <= down_next;
        right_reg <= right_next;
        eor_reg   <= eor_next;
        last_reg  <= last_next;
        pix_reg   <= pix_next;
        idx_reg   <= idx_next;
        ch_reg    <= ch_next;
        acc_reg   <= acc_next;
        bestd_reg <= bestd_next;
        best_reg  <= best_next;
        err_reg   <= err_next;
        tgt_reg   <= tgt_next;
        out_reg   <= out_next;
    end

endmodule
